### sv/assert_macros.svh
// Assertion macros used by the RTL top level, wall_column_projection.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// signal has no X or Z outside reset
`define ASSERT_KNOWN(label, clk, rst_n, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
        else $error("signal unknown");

`endif

### sv/wcp_pkg.sv
// Constants and helpers for the wall column projection pipeline.
// No dependencies.
`default_nettype none
package wcp_pkg;
    localparam int ScreenHeight = 512;
    localparam int TextureSize  = 64;
    localparam int FracBits     = 16;
    localparam int HalfScreen   = ScreenHeight / 2;
    localparam int RowW         = 9;
    localparam int TcolW        = 6;
    localparam int StartMax     = 4194303;
    // pipeline depth of each division unit
    localparam int DivSteps     = 32;
endpackage
`default_nettype wire

### sv/wcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, valid travels along.
// Depends on wcp_pkg.
`default_nettype none
module wcp_div
    import wcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_valid,
    output logic [31:0]      o_quot
);
    logic                    r_v   [1:DivSteps];
    logic [31:0]             r_rem [1:DivSteps];
    logic [31:0]             r_num [1:DivSteps];
    logic [31:0]             r_den [1:DivSteps];
    logic [31:0]             r_q   [1:DivSteps];

    for (genvar k = 0; k < DivSteps; k++) begin : g_st
        logic        v_in;
        logic [31:0] rem_in, num_in, den_in, q_in;
        logic [32:0] n_trial;
        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = r_v[k];
            assign rem_in = r_rem[k];
            assign num_in = r_num[k];
            assign den_in = r_den[k];
            assign q_in   = r_q[k];
        end
        assign n_trial = {rem_in, num_in[31]} - {1'b0, den_in};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k+1] <= 1'b0;
            else          r_v[k+1] <= v_in;
            r_num[k+1] <= {num_in[30:0], 1'b0};
            r_den[k+1] <= den_in;
            if (!n_trial[32]) begin
                r_rem[k+1] <= n_trial[31:0];
                r_q[k+1]   <= {q_in[30:0], 1'b1};
            end else begin
                r_rem[k+1] <= {rem_in[30:0], num_in[31]};
                r_q[k+1]   <= {q_in[30:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[DivSteps];
    assign o_quot  = r_q[DivSteps];
endmodule
`default_nettype wire

### sv/wall_column_projection.sv
// Channel   | signals                       | direction
// command   | i_start/o_busy + input words  | in
// result    | o_valid + output words        | out
// One word accepted per cycle (o_busy is always low).
// Two 32-stage divider pipelines (height, texture step) set the latency.
// Synchronous active-low reset clears all valid bits; results cannot be stalled.
// Top level: wall column projection pipeline. Depends on wcp_pkg, wcp_div, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module wall_column_projection
    import wcp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_hit_side,
    input  wire logic        [31:0] i_side_dist_x,
    input  wire logic        [31:0] i_side_dist_y,
    input  wire logic        [31:0] i_delta_dist_x,
    input  wire logic        [31:0] i_delta_dist_y,
    input  wire logic signed [17:0] i_dir_x,
    input  wire logic signed [17:0] i_dir_y,
    input  wire logic        [23:0] i_pos_x,
    input  wire logic        [23:0] i_pos_y,
    output logic                    o_valid,
    output logic             [31:0] o_wall_distance,
    output logic             [15:0] o_slice_height,
    output logic             [8:0]  o_first_row,
    output logic             [8:0]  o_last_row,
    output logic             [5:0]  o_texture_column,
    output logic             [22:0] o_texture_step,
    output logic             [21:0] o_texture_start
);
    localparam int Lat = 2 * DivSteps + 4;
    localparam logic [31:0] HNum = 32'(ScreenHeight) << FracBits;
    localparam logic [31:0] TNum = 32'(TextureSize) << FracBits;

    assign o_busy = 1'b0;

    // stage 1: distance, side selects
    logic        r1_v, r1_pos;
    logic [31:0] r1_dist;
    logic signed [17:0] r1_dir;
    logic [15:0] r1_posf;
    logic        r1_mir;
    always_ff @(posedge i_clk) begin
        logic [31:0] sd, dd;
        sd = i_hit_side ? i_side_dist_y : i_side_dist_x;
        dd = i_hit_side ? i_delta_dist_y : i_delta_dist_x;
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= i_start;
        r1_pos  <= sd > dd;
        r1_dist <= (sd > dd) ? sd - dd : '0;
        r1_dir  <= i_hit_side ? i_dir_x : i_dir_y;
        r1_posf <= i_hit_side ? i_pos_x[15:0] : i_pos_y[15:0];
        r1_mir  <= (!i_hit_side && i_dir_x > 0) || (i_hit_side && i_dir_y < 0);
    end

    // stage 2: hit product
    logic        r2_v, r2_pos;
    logic [31:0] r2_dist;
    logic [5:0]  r2_tcol;
    always_ff @(posedge i_clk) begin
        logic signed [50:0] prod;
        logic [15:0] fr;
        prod = $signed({1'b0, r1_dist}) * r1_dir;
        fr = r1_posf + prod[31:16];
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_pos  <= r1_pos;
        r2_dist <= r1_dist;
        r2_tcol <= r1_mir ? 6'(TextureSize - 1) - fr[15:10] : fr[15:10];
    end

    logic        hv;
    logic [31:0] hq;
    wcp_div u_hdiv (.i_clk, .i_rst_n, .i_valid(r2_v), .i_num(HNum),
        .i_den(r2_pos ? r2_dist : 32'd1), .o_valid(hv), .o_quot(hq));

    // side data delayed alongside the height divider
    logic [31:0] r_dd [DivSteps];
    logic [5:0]  r_dt [DivSteps];
    logic [DivSteps-1:0] r_dp;
    always_ff @(posedge i_clk) begin
        r_dd[0] <= r2_dist; r_dt[0] <= r2_tcol; r_dp[0] <= r2_pos;
        for (int k = 1; k < DivSteps; k++) begin
            r_dd[k] <= r_dd[k-1]; r_dt[k] <= r_dt[k-1]; r_dp[k] <= r_dp[k-1];
        end
    end

    // stage 3: height clamp and rows
    logic        r3_v;
    logic [31:0] r3_dist;
    logic [5:0]  r3_tcol;
    logic [15:0] r3_h;
    logic [8:0]  r3_first, r3_last;
    logic [14:0] r3_offs;
    always_ff @(posedge i_clk) begin
        logic [15:0] h;
        logic [14:0] hh;
        if (!r_dp[DivSteps-1])   h = 16'(ScreenHeight);
        else if (hq > 32'hFFFF)  h = 16'hFFFF;
        else if (hq == 0)        h = 16'd1;
        else                     h = hq[15:0];
        hh = h[15:1];
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= hv;
        r3_dist  <= r_dd[DivSteps-1];
        r3_tcol  <= r_dt[DivSteps-1];
        r3_h     <= h;
        r3_first <= (hh > 15'(HalfScreen)) ? '0 : 9'(15'(HalfScreen) - hh);
        r3_last  <= (16'(hh) + 16'(HalfScreen) >= 16'(ScreenHeight)) ?
                    9'(ScreenHeight - 1) : 9'(16'(hh) + 16'(HalfScreen));
        // rows clipped above the screen
        r3_offs  <= (hh > 15'(HalfScreen)) ? hh - 15'(HalfScreen) : '0;
    end

    logic        sv_;
    logic [31:0] sq;
    wcp_div u_sdiv (.i_clk, .i_rst_n, .i_valid(r3_v), .i_num(TNum),
        .i_den({16'd0, r3_h}), .o_valid(sv_), .o_quot(sq));

    logic [31:0] r_ed [DivSteps];
    logic [5:0]  r_et [DivSteps];
    logic [15:0] r_eh [DivSteps];
    logic [8:0]  r_ef [DivSteps], r_el [DivSteps];
    logic [14:0] r_eo [DivSteps];
    always_ff @(posedge i_clk) begin
        r_ed[0] <= r3_dist; r_et[0] <= r3_tcol; r_eh[0] <= r3_h;
        r_ef[0] <= r3_first; r_el[0] <= r3_last; r_eo[0] <= r3_offs;
        for (int k = 1; k < DivSteps; k++) begin
            r_ed[k] <= r_ed[k-1]; r_et[k] <= r_et[k-1]; r_eh[k] <= r_eh[k-1];
            r_ef[k] <= r_ef[k-1]; r_el[k] <= r_el[k-1]; r_eo[k] <= r_eo[k-1];
        end
    end

    // stage 4: start product, outputs
    always_ff @(posedge i_clk) begin
        logic [37:0] st;
        st = 38'(r_eo[DivSteps-1]) * 38'(sq[22:0]);
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= sv_;
        o_wall_distance  <= r_ed[DivSteps-1];
        o_slice_height   <= r_eh[DivSteps-1];
        o_first_row      <= r_ef[DivSteps-1];
        o_last_row       <= r_el[DivSteps-1];
        o_texture_column <= r_et[DivSteps-1];
        o_texture_step   <= sq[22:0];
        o_texture_start  <= (st > 38'(StartMax)) ? 22'(StartMax) : st[21:0];
    end

    logic [Lat-1:0] r_chk;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_chk <= '0;
        else          r_chk <= {r_chk[Lat-2:0], i_start};
    end

    `ASSERT_CLK(a_lat, i_clk, i_rst_n, o_valid == r_chk[Lat-1])
    `ASSERT_CLK(a_h, i_clk, i_rst_n, o_valid |-> o_slice_height != 16'd0)
    `ASSERT_CLK(a_rows, i_clk, i_rst_n, o_valid |-> o_first_row <= o_last_row)
    `ASSERT_KNOWN(a_known, i_clk, i_rst_n, o_valid)
endmodule
`default_nettype wire
